>>> hw/rtl/rmat_edge_generator_unit_assert.svh
// Assertion macros shared by the edge generator RTL.
`ifndef RMAT_EDGE_GENERATOR_UNIT_ASSERT_SVH
`define RMAT_EDGE_GENERATOR_UNIT_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define RMAT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rmat check failed");
// Next-cycle implication, checked outside reset.
`define RMAT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rmat check failed");
`endif

>>> hw/rtl/rmat_pkg.sv
// Package with constants, types and twister functions of the edge generator.
`default_nettype none
package rmat_pkg;
  localparam int unsigned MaxScale   = 32;
  localparam int unsigned StateWords = 312;
  localparam int unsigned TwMid      = 156;
  localparam int unsigned AddrW      = $clog2(StateWords);
  localparam logic [63:0] TwMatrix   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TwUpper    = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TwLower    = 64'h000000007FFFFFFF;
  localparam logic [63:0] TwInitMul  = 64'd6364136223846793005;

  localparam logic [2:0] RegBaseSeed  = 3'd0;
  localparam logic [2:0] RegScale     = 3'd1;
  localparam logic [2:0] RegThreshA   = 3'd2;
  localparam logic [2:0] RegThreshAb  = 3'd3;
  localparam logic [2:0] RegThreshAbc = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_SEED, ST_SEED_END, ST_RD_A,
    ST_RD_B, ST_RD_C, ST_TWIST, ST_CMP, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MAC_HOLD, MAC_LOAD, MAC_HIGH
  } mac_op_e;

  typedef struct packed {
    mac_op_e          op;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [AddrW-1:0] addend;
  } mac_ctl_t;

  function automatic logic [63:0] tw_twist(input logic [63:0] cur, input logic [63:0] nxt,
                                           input logic [63:0] mid);
    logic [63:0] y;
    y = (cur & TwUpper) | (nxt & TwLower);
    return mid ^ (y >> 1) ^ (y[0] ? TwMatrix : 64'd0);
  endfunction

  function automatic logic [63:0] tw_temper(input logic [63:0] v);
    logic [63:0] w;
    w = v;
    w = w ^ ((w >> 29) & 64'h5555555555555555);
    w = w ^ ((w << 17) & 64'h71D67FFFEDA60000);
    w = w ^ ((w << 37) & 64'hFFF7EEE000000000);
    w = w ^ (w >> 43);
    return w;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/rmat_if.sv
// Valid/ready channel interfaces for edge indexes and vertex pairs.
`default_nettype none
interface rmat_edge_if;
  logic        valid;
  logic        ready;
  logic [63:0] edge_index;
  modport source (output valid, output edge_index, input ready);
  modport sink (input valid, input edge_index, output ready);
endinterface

interface rmat_vtx_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_vertex;
  logic [31:0] dst_vertex;
  modport source (output valid, output src_vertex, output dst_vertex, input ready);
  modport sink (input valid, input src_vertex, input dst_vertex, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rmat_mac.sv
// Shared 32x32 multiply-accumulate unit that builds 64-bit products in steps.
`default_nettype none
module rmat_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmat_pkg::mac_ctl_t ctl_i,
  output logic [63:0]       acc_o
);
  import rmat_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [63:0] prod;

  assign prod = 64'(ctl_i.a) * 64'(ctl_i.b);

  always_comb begin
    acc_d = acc_q;
    case (ctl_i.op)
      MAC_LOAD: acc_d = prod + 64'(ctl_i.addend);
      MAC_HIGH: acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 64'd0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

>>> hw/rtl/rmat_edge_generator_unit.sv
// Top level of the R-MAT edge generator with its twister sequencer.
//
// Channel  Dir  Payload                   Handshake
// edge_i   in   edge_index[63:0]          valid/ready
// vtx_o    out  src_vertex, dst_vertex    valid/ready
// cfg      in   cfg_idx_i, cfg_data_i     cfg_we_i, no wait
//
// Each item's seeding multiplies run on the single 32x32 multiplier; an item
// makes as many draws as the scale, saturated at 32.
// Reset clears FSM state, output valid and config registers, not twister memory.
// A result waits in the output register; the next item is taken once it has left
// or while it waits, but the sequencer holds at its end until the register is free.
`default_nettype none
`include "rmat_edge_generator_unit_assert.svh"
module rmat_edge_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmat_edge_if.sink           edge_i,
  rmat_vtx_if.source          vtx_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  import rmat_pkg::*;

  logic [63:0] base_seed_q, thr_a_q, thr_ab_q, thr_abc_q;
  logic [5:0]  scale_q;
  state_e      state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [5:0]  k_q, k_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] cur_q, cur_d, nxt_q, nxt_d, draw_q, draw_d;
  logic [31:0] src_q, src_d, dst_q, dst_d;
  logic        ov_q, ov_d;
  logic [31:0] osrc_q, osrc_d, odst_q, odst_d;

  logic [63:0] mem [StateWords];
  logic [63:0] rdata_q;
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0] wdata;

  mac_ctl_t    mac_ctl;
  logic [63:0] acc;
  logic [63:0] pval, xval;
  logic [5:0]  scale_eff;
  logic [AddrW-1:0] last_idx;
  logic        sb, db;

  rmat_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  assign scale_eff = (scale_q > 6'(MaxScale)) ? 6'(MaxScale) : scale_q;
  assign last_idx  = AddrW'(TwMid - 1) + AddrW'(scale_eff);
  assign pval      = (idx_q == AddrW'(1)) ? seed_q : acc;
  assign xval      = pval ^ (pval >> 62);
  assign edge_i.ready = (state_q == ST_IDLE);
  assign vtx_o.valid  = ov_q;
  assign vtx_o.src_vertex = osrc_q;
  assign vtx_o.dst_vertex = odst_q;

  always_comb begin
    if (draw_q <= thr_a_q) begin
      sb = 1'b0; db = 1'b0;
    end else if (draw_q <= thr_ab_q) begin
      sb = 1'b0; db = 1'b1;
    end else if (draw_q <= thr_abc_q) begin
      sb = 1'b1; db = 1'b0;
    end else begin
      sb = 1'b1; db = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    k_d     = k_q;
    seed_d  = seed_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    draw_d  = draw_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ov_d    = ov_q && !vtx_o.ready;
    osrc_d  = osrc_q;
    odst_d  = odst_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = acc;
    raddr   = AddrW'(k_q);
    mac_ctl = '{op: MAC_HOLD, a: 32'd0, b: 32'd0, addend: '0};
    case (state_q)
      ST_IDLE: begin
        if (edge_i.valid) begin
          seed_d  = base_seed_q + edge_i.edge_index;
          src_d   = 32'd0;
          dst_d   = 32'd0;
          k_d     = 6'd0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = seed_q;
        idx_d   = AddrW'(1);
        phase_d = 2'd0;
        state_d = ST_SEED;
      end
      ST_SEED: begin
        case (phase_q)
          2'd0: begin
            if (idx_q != AddrW'(1)) begin
              we    = 1'b1;
              waddr = idx_q - AddrW'(1);
            end
            mac_ctl = '{op: MAC_LOAD, a: xval[31:0], b: TwInitMul[31:0], addend: idx_q};
            cur_d   = xval;
            phase_d = 2'd1;
          end
          2'd1: begin
            mac_ctl = '{op: MAC_HIGH, a: cur_q[63:32], b: TwInitMul[31:0], addend: '0};
            phase_d = 2'd2;
          end
          default: begin
            mac_ctl = '{op: MAC_HIGH, a: cur_q[31:0], b: TwInitMul[63:32], addend: '0};
            phase_d = 2'd0;
            if (idx_q == last_idx) begin
              state_d = ST_SEED_END;
            end else begin
              idx_d = idx_q + AddrW'(1);
            end
          end
        endcase
      end
      ST_SEED_END: begin
        we      = 1'b1;
        state_d = (scale_eff == 6'd0) ? ST_FIN : ST_RD_A;
      end
      ST_RD_A: begin
        raddr   = '0;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        if (k_q == 6'd0) begin
          cur_d = rdata_q;
        end
        raddr   = AddrW'(k_q) + AddrW'(1);
        state_d = ST_RD_C;
      end
      ST_RD_C: begin
        nxt_d   = rdata_q;
        raddr   = AddrW'(k_q) + AddrW'(TwMid);
        state_d = ST_TWIST;
      end
      ST_TWIST: begin
        draw_d  = tw_temper(tw_twist(cur_q, nxt_q, rdata_q));
        state_d = ST_CMP;
      end
      ST_CMP: begin
        src_d = {src_q[30:0], sb};
        dst_d = {dst_q[30:0], db};
        cur_d = nxt_q;
        k_d   = k_q + 6'd1;
        state_d = (k_q + 6'd1 < scale_eff) ? ST_RD_B : ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || vtx_o.ready) begin
          state_d = ST_IDLE;
          if (src_q != dst_q) begin
            ov_d   = 1'b1;
            osrc_d = (src_q < dst_q) ? src_q : dst_q;
            odst_d = (src_q < dst_q) ? dst_q : src_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    seed_q  <= seed_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    draw_q  <= draw_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    osrc_q  <= osrc_d;
    odst_q  <= odst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_seed_q <= 64'd0;
      scale_q     <= 6'd16;
      thr_a_q     <= 64'd0;
      thr_ab_q    <= 64'd0;
      thr_abc_q   <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBaseSeed:  base_seed_q <= cfg_data_i;
        RegScale:     scale_q     <= cfg_data_i[5:0];
        RegThreshA:   thr_a_q     <= cfg_data_i;
        RegThreshAb:  thr_ab_q    <= cfg_data_i;
        RegThreshAbc: thr_abc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `RMAT_ASSERT_NOW(a_out_ordered, ov_q, osrc_q < odst_q)
  `RMAT_ASSERT_NEXT(a_accept_busy, edge_i.valid && edge_i.ready, state_q == ST_START)
  `RMAT_ASSERT_NOW(a_draw_in_range, state_q == ST_CMP, k_q < scale_eff)
endmodule
`default_nettype wire

>>> sim/rmat_edge_generator_unit_tb.sv
// Self-checking testbench of the R-MAT edge generator with a built-in twister predictor.
`timescale 1ns / 100ps
module rmat_edge_generator_unit_tb;
  import rmat_pkg::*;

  localparam logic [2:0] RegUnused0 = 3'd5;
  localparam logic [2:0] RegUnused1 = 3'd7;
  localparam int unsigned DrainCycles = 900;
  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  rmat_edge_if edge_ch ();
  rmat_vtx_if vtx_ch ();

  rmat_edge_generator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (edge_ch.sink),
    .vtx_o      (vtx_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [63:0] seed_q;
  logic [5:0] scale_q;
  logic [63:0] thr_a_q, thr_ab_q, thr_abc_q;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } vtx_pair_t;

  vtx_pair_t pending_pairs[$];
  int errors = 0;
  int edges_sent = 0;
  int pairs_seen = 0;
  int burst_left = 0;
  int gap_max = 10;
  int stall_period = 1;
  int stall_duty = 1;
  int cyc = 0;
  int quiet_cycles = 0;

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.edge_index = '0;
    vtx_ch.ready = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void predict_edge(input logic [63:0] idx, output bit hit,
                                       output vtx_pair_t pair);
    logic [63:0] tw[StateWords];
    logic [63:0] y, w;
    logic [31:0] s, d;
    int n;
    tw[0] = seed_q + idx;
    for (int k = 1; k < StateWords; k++) begin
      tw[k] = 64'd6364136223846793005 * (tw[k-1] ^ (tw[k-1] >> 62)) + 64'(k);
    end
    n = (scale_q > 6'd32) ? 32 : int'(scale_q);
    s = '0;
    d = '0;
    for (int k = 0; k < n; k++) begin
      y = (tw[k] & 64'hFFFFFFFF80000000) | (tw[k+1] & 64'h000000007FFFFFFF);
      w = tw[k+156] ^ (y >> 1) ^ (y[0] ? 64'hB5026F5AA96619E9 : 64'd0);
      tw[k] = w;
      w = w ^ ((w >> 29) & 64'h5555555555555555);
      w = w ^ ((w << 17) & 64'h71D67FFFEDA60000);
      w = w ^ ((w << 37) & 64'hFFF7EEE000000000);
      w = w ^ (w >> 43);
      if (w <= thr_a_q) begin
        s = {s[30:0], 1'b0}; d = {d[30:0], 1'b0};
      end else if (w <= thr_ab_q) begin
        s = {s[30:0], 1'b0}; d = {d[30:0], 1'b1};
      end else if (w <= thr_abc_q) begin
        s = {s[30:0], 1'b1}; d = {d[30:0], 1'b0};
      end else begin
        s = {s[30:0], 1'b1}; d = {d[30:0], 1'b1};
      end
    end
    hit = (s != d);
    pair.src = (s < d) ? s : d;
    pair.dst = (s < d) ? d : s;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      RegBaseSeed: seed_q = data;
      RegScale: scale_q = data[5:0];
      RegThreshA: thr_a_q = data;
      RegThreshAb: thr_ab_q = data;
      RegThreshAbc: thr_abc_q = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(input logic [63:0] seed, input logic [5:0] scale,
                       input logic [63:0] a, input logic [63:0] ab, input logic [63:0] abc);
    write_reg(RegBaseSeed, seed);
    write_reg(RegScale, {58'd0, scale});
    write_reg(RegThreshA, a);
    write_reg(RegThreshAb, ab);
    write_reg(RegThreshAbc, abc);
  endtask

  task automatic setup_realistic(input logic [5:0] scale);
    logic [63:0] t0, t1, t2, tmp;
    t0 = rand64();
    t1 = rand64();
    t2 = rand64();
    if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
    if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
    if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
    setup(rand64(), scale, t0, t1, t2);
  endtask

  task automatic drain();
    edge_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_edge(input logic [63:0] idx);
    bit hit;
    vtx_pair_t pair;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        edge_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    edge_ch.valid <= 1'b1;
    edge_ch.edge_index <= idx;
    do @(posedge clk_i); while (!edge_ch.ready);
    predict_edge(idx, hit, pair);
    if (hit) pending_pairs.push_back(pair);
    edges_sent++;
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    vtx_ch.ready <= (cyc % stall_period) < stall_duty;
    if (vtx_ch.valid && vtx_ch.ready) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected pair expected none actual %h %h", $time,
                 vtx_ch.src_vertex, vtx_ch.dst_vertex);
      end else begin
        if (vtx_ch.src_vertex !== pending_pairs[0].src) begin
          errors++;
          $display("%0t: src_vertex expected %h actual %h", $time,
                   pending_pairs[0].src, vtx_ch.src_vertex);
        end
        if (vtx_ch.dst_vertex !== pending_pairs[0].dst) begin
          errors++;
          $display("%0t: dst_vertex expected %h actual %h", $time,
                   pending_pairs[0].dst, vtx_ch.dst_vertex);
        end
        void'(pending_pairs.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((edge_ch.valid && edge_ch.ready) || (vtx_ch.valid && vtx_ch.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("timeout with %0d pairs pending", pending_pairs.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_stall(input int period, input int duty);
    stall_period = period;
    stall_duty = duty;
  endtask

  task automatic test_reset_defaults();
    seed_q = '0;
    scale_q = 6'd16;
    thr_a_q = '0;
    thr_ab_q = '0;
    thr_abc_q = '0;
    send_edge(64'd0);
    send_edge(64'hFFFFFFFFFFFFFFFF);
    drain();
  endtask

  task automatic test_field_extremes();
    setup(64'd5489, 6'd32, 64'h9000000000000000, 64'hC000000000000000,
          64'hF000000000000000);
    send_edge(64'd0);
    send_edge(64'd1);
    send_edge(64'hFFFFFFFFFFFFFFFF);
    send_edge(64'h8000000000000000);
    send_edge(64'h5555555555555555);
    send_edge(64'hAAAAAAAAAAAAAAAA);
    drain();
    setup(64'hFFFFFFFFFFFFFFFF, 6'd1, 64'h4000000000000000, 64'h8000000000000000,
          64'hC000000000000000);
    for (int i = 0; i < 6; i++) send_edge(64'(i));
    drain();
  endtask

  task automatic test_special_cases();
    setup(64'd7, 6'd0, 64'h4000000000000000, 64'h8000000000000000,
          64'hC000000000000000);
    send_edge(64'd3);
    send_edge(64'd4);
    drain();
    write_reg(RegScale, 64'hFFFFFFFFFFFFFF3F);
    send_edge(64'd11);
    send_edge(64'd12);
    drain();
    write_reg(RegScale, 64'd40);
    send_edge(64'd13);
    drain();
    setup(64'd99, 6'd8, 64'hC000000000000000, 64'h4000000000000000,
          64'h8000000000000000);
    send_edge(64'd1);
    send_edge(64'd2);
    drain();
    setup(64'hFFFFFFFFFFFFFFF0, 6'd12, 64'h3000000000000000, 64'h7000000000000000,
          64'hB000000000000000);
    send_edge(64'd15);
    send_edge(64'd16);
    send_edge(64'd100);
    drain();
    write_reg(RegUnused0, rand64());
    write_reg(RegUnused1, rand64());
    send_edge(64'd17);
    drain();
    setup(64'd1, 6'd10, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
          64'hFFFFFFFFFFFFFFFF);
    send_edge(64'd5);
    drain();
  endtask

  task automatic test_random_edges();
    int scale;
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: scale = $urandom_range(1, 12);
        1: scale = $urandom_range(1, 32);
        2: scale = (ph == 6) ? 63 : 32;
        default: scale = $urandom_range(2, 6);
      endcase
      setup_realistic(6'(scale));
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 40);
      if (ph % 3 == 1) set_stall(1, 1);
      else set_stall($urandom_range(2, 40), $urandom_range(1, 20));
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 15) == 0) send_edge(64'hFFFFFFFFFFFFFFFF - 64'(i));
        else send_edge(rand64());
        if (i == 75 && ph == 4) begin
          edge_ch.valid <= 1'b0;
          burst_left = 0;
          while (pending_pairs.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_stall(3, 2);
    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_random_edges();
    $display("Sent %0d edge indexes across directed and random phases;", edges_sent);
    $display("checked %0d vertex pairs.", pairs_seen);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
